// File: design/sam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sam_pkg;
  localparam int ALPHABET  = 26;
  localparam int MAX_TEXT  = 1024;
  localparam int NODE_W    = 11;
  localparam int LEN_W     = 11;
  localparam int CNT_W     = 12;
  localparam int LET_W     = 5;
  localparam int MAX_NODES = 2 * MAX_TEXT;

  localparam logic [1:0] F_CLEAR  = 2'd0;
  localparam logic [1:0] F_APPEND = 2'd1;
  localparam logic [1:0] F_QSTART = 2'd2;
  localparam logic [1:0] F_QCONT  = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE, S_ZROW,
    S_A_RDT, S_A_WT, S_A_RDL, S_A_WL,
    S_A_RNP, S_A_WNP, S_A_RNQ, S_A_WNQ,
    S_A_CPR, S_A_CPW, S_A_RSQ, S_A_WSQ, S_A_SL1, S_A_SL2,
    S_A_R2T, S_A_W2T, S_A_R2L, S_A_W2L,
    S_Q_RDT, S_Q_WT, S_Q_RDL, S_Q_WL, S_Q_RNX, S_Q_WNX,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

// File: design/suffix_automaton_build_match.sv
`timescale 1ns / 1ps
`default_nettype none
// Clear sweeps the root row; a query walks suffix links until a transition is found,
// and an append walks suffix links and copies the transition row when a node is cloned.
// One beat at a time: s_tready is high only in idle, so the row sweeps and link walks
// over the tables hold off the next letter until the result has been emitted.
// Reset: synchronous; the root row is swept to zero before the first beat.
module suffix_automaton_build_match (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // func[1:0], letter[6:2]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata   // match_length[10:0], node_count[22:11], overflow[23]
);
  localparam int NW = sam_pkg::NODE_W;
  localparam int LW = sam_pkg::LEN_W;
  localparam int TW = NW + sam_pkg::LET_W;
  localparam logic [sam_pkg::CNT_W-1:0] CNT_ONE = 1;

  sam_pkg::state_t st, st_next;

  logic [NW-1:0] p, q, np, nq, zrow, qn, last;
  logic [LW-1:0] zlen, nlp, ql, tlen;
  logic [sam_pkg::CNT_W-1:0] nodes;
  logic [sam_pkg::LET_W-1:0] c, idx;
  logic zapp, first, ovf, boot;
  logic [LW-1:0] o_ml;
  logic [sam_pkg::CNT_W-1:0] o_nc;
  logic o_ov;

  logic          tt_we, sl_we, nl_we;
  logic [TW-1:0] tt_wa, tt_ra;
  logic [NW-1:0] tt_wd, tt_rd, sl_wa, sl_wd, sl_ra, sl_rd, nl_wa, nl_ra;
  logic [LW-1:0] nl_wd, nl_rd;

  logic [1:0]               in_func;
  logic [sam_pkg::LET_W-1:0] in_let;
  logic                     out_free;

  assign in_func  = s_tdata[1:0];
  assign in_let   = s_tdata[6:2];
  assign s_tready = (st == sam_pkg::S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {o_ov, o_nc, o_ml};

  sam_ram #(.AW(TW), .DW(NW)) u_tt (
    .clk(clk), .we(tt_we), .waddr(tt_wa), .wdata(tt_wd), .raddr(tt_ra), .rdata(tt_rd)
  );
  sam_ram #(.AW(NW), .DW(NW)) u_sl (
    .clk(clk), .we(sl_we), .waddr(sl_wa), .wdata(sl_wd), .raddr(sl_ra), .rdata(sl_rd)
  );
  sam_ram #(.AW(NW), .DW(LW)) u_nl (
    .clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd)
  );

  always_comb begin
    st_next = st;
    tt_we = 1'b0; tt_wa = {p, c}; tt_wd = '0; tt_ra = {p, c};
    sl_we = 1'b0; sl_wa = np; sl_wd = '0; sl_ra = p;
    nl_we = 1'b0; nl_wa = zrow; nl_wd = zlen; nl_ra = p;
    case (st)
      sam_pkg::S_IDLE: begin
        if (s_tvalid) begin
          case (in_func)
            sam_pkg::F_CLEAR: st_next = sam_pkg::S_ZROW;
            sam_pkg::F_APPEND: begin
              if (32'(tlen) >= sam_pkg::MAX_TEXT || 32'(in_let) >= sam_pkg::ALPHABET) begin
                st_next = sam_pkg::S_DONE;
              end else begin
                st_next = sam_pkg::S_ZROW;
              end
            end
            default: begin
              if (32'(in_let) >= sam_pkg::ALPHABET) st_next = sam_pkg::S_DONE;
              else st_next = sam_pkg::S_Q_RDT;
            end
          endcase
        end
      end
      sam_pkg::S_ZROW: begin
        tt_we = 1'b1; tt_wa = {zrow, idx};
        if (idx == '0) begin
          nl_we = 1'b1;
          sl_we = 1'b1; sl_wa = zrow;
        end
        if (32'(idx) == sam_pkg::ALPHABET - 1) begin
          if (zapp) st_next = sam_pkg::S_A_RDT;
          else st_next = boot ? sam_pkg::S_IDLE : sam_pkg::S_DONE;
        end
      end
      sam_pkg::S_A_RDT: st_next = sam_pkg::S_A_WT;
      sam_pkg::S_A_WT: begin
        if (tt_rd == '0) begin
          tt_we = 1'b1; tt_wd = np;
          st_next = (p == '0) ? sam_pkg::S_DONE : sam_pkg::S_A_RDL;
        end else begin
          st_next = sam_pkg::S_A_RNP;
        end
      end
      sam_pkg::S_A_RDL: st_next = sam_pkg::S_A_WL;
      sam_pkg::S_A_WL:  st_next = sam_pkg::S_A_RDT;
      sam_pkg::S_A_RNP: st_next = sam_pkg::S_A_WNP;
      sam_pkg::S_A_WNP: st_next = sam_pkg::S_A_RNQ;
      sam_pkg::S_A_RNQ: begin
        nl_ra = q;
        st_next = sam_pkg::S_A_WNQ;
      end
      sam_pkg::S_A_WNQ: begin
        if (LW'(nlp + 1'b1) == nl_rd) begin
          sl_we = 1'b1; sl_wd = q;
          st_next = sam_pkg::S_DONE;
        end else begin
          nl_we = 1'b1; nl_wa = nodes[NW-1:0]; nl_wd = LW'(nlp + 1'b1);
          st_next = sam_pkg::S_A_CPR;
        end
      end
      sam_pkg::S_A_CPR: begin
        tt_ra = {q, idx};
        st_next = sam_pkg::S_A_CPW;
      end
      sam_pkg::S_A_CPW: begin
        tt_we = 1'b1; tt_wa = {nq, idx}; tt_wd = tt_rd;
        st_next = (32'(idx) == sam_pkg::ALPHABET - 1) ? sam_pkg::S_A_RSQ : sam_pkg::S_A_CPR;
      end
      sam_pkg::S_A_RSQ: begin
        sl_ra = q;
        st_next = sam_pkg::S_A_WSQ;
      end
      sam_pkg::S_A_WSQ: begin
        sl_we = 1'b1; sl_wa = nq; sl_wd = sl_rd;
        st_next = sam_pkg::S_A_SL1;
      end
      sam_pkg::S_A_SL1: begin
        sl_we = 1'b1; sl_wa = q; sl_wd = nq;
        st_next = sam_pkg::S_A_SL2;
      end
      sam_pkg::S_A_SL2: begin
        sl_we = 1'b1; sl_wa = np; sl_wd = nq;
        st_next = sam_pkg::S_A_R2T;
      end
      sam_pkg::S_A_R2T: st_next = sam_pkg::S_A_W2T;
      sam_pkg::S_A_W2T: begin
        if (tt_rd == q) begin
          tt_we = 1'b1; tt_wd = nq;
          st_next = (p == '0) ? sam_pkg::S_DONE : sam_pkg::S_A_R2L;
        end else begin
          st_next = sam_pkg::S_DONE;
        end
      end
      sam_pkg::S_A_R2L: st_next = sam_pkg::S_A_W2L;
      sam_pkg::S_A_W2L: st_next = sam_pkg::S_A_R2T;
      sam_pkg::S_Q_RDT: st_next = sam_pkg::S_Q_WT;
      sam_pkg::S_Q_WT: begin
        if (tt_rd != '0) st_next = first ? sam_pkg::S_DONE : sam_pkg::S_Q_RNX;
        else if (p == '0) st_next = sam_pkg::S_DONE;
        else st_next = sam_pkg::S_Q_RDL;
      end
      sam_pkg::S_Q_RDL: st_next = sam_pkg::S_Q_WL;
      sam_pkg::S_Q_WL:  st_next = sam_pkg::S_Q_RDT;
      sam_pkg::S_Q_RNX: st_next = sam_pkg::S_Q_WNX;
      sam_pkg::S_Q_WNX: st_next = sam_pkg::S_DONE;
      sam_pkg::S_DONE: begin
        if (out_free) st_next = sam_pkg::S_IDLE;
      end
      default: st_next = sam_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sam_pkg::S_ZROW;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes <= CNT_ONE; last <= '0; tlen <= '0; qn <= '0; ql <= '0;
      zrow <= '0; zlen <= '0; zapp <= 1'b0; idx <= '0; ovf <= 1'b0;
      boot <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !(st == sam_pkg::S_DONE && out_free)) m_tvalid <= 1'b0;
      case (st)
        sam_pkg::S_IDLE: begin
          idx <= '0; c <= in_let;
          ovf <= s_tvalid && in_func == sam_pkg::F_APPEND &&
                 32'(tlen) >= sam_pkg::MAX_TEXT;
          if (s_tvalid) begin
            case (in_func)
              sam_pkg::F_CLEAR: begin
                nodes <= CNT_ONE; last <= '0; tlen <= '0; qn <= '0; ql <= '0;
                zrow <= '0; zlen <= '0; zapp <= 1'b0;
              end
              sam_pkg::F_APPEND: begin
                if (32'(tlen) < sam_pkg::MAX_TEXT && 32'(in_let) < sam_pkg::ALPHABET) begin
                  zrow <= nodes[NW-1:0]; zlen <= LW'(tlen + 1'b1); zapp <= 1'b1;
                  np <= nodes[NW-1:0]; p <= last; last <= nodes[NW-1:0];
                  nodes <= nodes + 1'b1; tlen <= LW'(tlen + 1'b1);
                end
              end
              default: begin
                first <= 1'b1;
                if (32'(in_let) >= sam_pkg::ALPHABET) begin
                  qn <= '0; ql <= '0;
                end else if (in_func == sam_pkg::F_QSTART) begin
                  p <= '0; ql <= '0;
                end else begin
                  p <= qn;
                end
              end
            endcase
          end
        end
        sam_pkg::S_ZROW: begin
          idx <= idx + 1'b1;
          if (32'(idx) == sam_pkg::ALPHABET - 1) boot <= 1'b0;
        end
        sam_pkg::S_A_WT: q <= tt_rd;
        sam_pkg::S_A_WL, sam_pkg::S_A_W2L, sam_pkg::S_Q_WL: p <= sl_rd;
        sam_pkg::S_A_WNP: nlp <= nl_rd;
        sam_pkg::S_A_WNQ: begin
          if (LW'(nlp + 1'b1) != nl_rd) begin
            nq <= nodes[NW-1:0]; nodes <= nodes + 1'b1; idx <= '0;
          end
        end
        sam_pkg::S_A_CPW: idx <= idx + 1'b1;
        sam_pkg::S_Q_WT: begin
          if (tt_rd != '0) begin
            qn <= tt_rd;
            if (first) ql <= LW'(ql + 1'b1);
          end else if (p == '0) begin
            qn <= '0; ql <= '0;
          end
          first <= 1'b0;
        end
        sam_pkg::S_Q_WNX: ql <= LW'(nl_rd + 1'b1);
        sam_pkg::S_DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1; o_ml <= ql; o_nc <= nodes; o_ov <= ovf;
          end
        end
        default: ;
      endcase
    end
  end

  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    nodes >= CNT_ONE && 32'(nodes) <= sam_pkg::MAX_NODES)
    else $error("node count out of range");
  a_text_len: assert property (@(posedge clk) disable iff (rst)
    32'(tlen) <= sam_pkg::MAX_TEXT)
    else $error("text length beyond limit");
  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (st == sam_pkg::S_DONE && out_free) |=> m_tvalid && st == sam_pkg::S_IDLE)
    else $error("result not emitted");
  a_busy_valid_len: assert property (@(posedge clk) disable iff (rst)
    (st == sam_pkg::S_Q_WT && tt_rd != '0 && first) |=> 32'(ql) <= sam_pkg::MAX_TEXT)
    else $error("query length beyond text");
endmodule
`default_nettype wire

// File: design/sam_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sam_ram #(
  parameter int AW = 11,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
